// File: rtl/btiv_pkg.sv
// Shared types, widths and constants for the body-to-inertial velocity transform.
// Used by the CORDIC lanes, the merge stage, the divider and the top level.
// No dependencies.
package btiv_pkg;

  // Field widths of the stream items and the configuration register.
  localparam int ANG_W   = 15;
  localparam int VEL_W   = 24;
  localparam int OUT_W   = 32;
  localparam int FLOOR_W = 13;

  // CORDIC sizing: angle in Q28, x and y in Q30, sine and cosine in Q15.
  localparam int CORDIC_STEPS = 16;
  localparam int Z_W          = 32;
  localparam int XY_W         = 33;
  localparam int TRIG_W       = 17;

  // Datapath widths of the merge stage.
  localparam int P2_W  = 2 * TRIG_W;
  localparam int P3_W  = P2_W + TRIG_W;
  localparam int M_W   = 33;
  localparam int MV_W  = M_W + VEL_W;
  localparam int SUM_W = MV_W + 2;
  localparam int N1_W  = TRIG_W + VEL_W;
  localparam int SN_W  = TRIG_W + N1_W;

  // Divider: unsigned numerator and divisor magnitudes.
  localparam int NUM_W = N1_W;
  localparam int DEN_W = 16;

  // Pipeline depths.
  localparam int LANE_LAT  = CORDIC_STEPS + 2;
  localparam int MERGE_LAT = 5;
  localparam int DIV_LAT   = NUM_W;
  localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT + DIV_LAT + 1;

  // Stream payload widths.
  localparam int S_DATA_W = 192;
  localparam int M_DATA_W = 6 * OUT_W;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
  localparam logic signed [Z_W-1:0]  PI_Q28      = Z_W'(843314857);
  localparam logic signed [Z_W-1:0]  HALF_PI_Q28 = Z_W'(421657428);
  localparam logic [FLOOR_W-1:0]     FLOOR_RESET = FLOOR_W'(72);

  // Body velocities of one item.
  typedef struct packed {
    logic signed [VEL_W-1:0] u;
    logic signed [VEL_W-1:0] v;
    logic signed [VEL_W-1:0] w;
    logic signed [VEL_W-1:0] p;
    logic signed [VEL_W-1:0] q;
    logic signed [VEL_W-1:0] r;
  } vel_t;

  // Sine and cosine of the three Euler angles.
  typedef struct packed {
    logic signed [TRIG_W-1:0] sphi;
    logic signed [TRIG_W-1:0] cphi;
    logic signed [TRIG_W-1:0] sth;
    logic signed [TRIG_W-1:0] cth;
    logic signed [TRIG_W-1:0] spsi;
    logic signed [TRIG_W-1:0] cpsi;
  } trig_t;

  // Results that ride alongside the divider.
  typedef struct packed {
    logic signed [OUT_W-1:0] north;
    logic signed [OUT_W-1:0] east;
    logic signed [OUT_W-1:0] down;
    logic signed [OUT_W-1:0] pitch_rate;
    logic signed [VEL_W-1:0] p;
    logic                    flag;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] yaw_num;
    logic [NUM_W-1:0] roll_num;
    logic [DEN_W-1:0] den;
    logic             yaw_neg;
    logic             roll_neg;
    side_t            side;
  } div_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] yaw_quo;
    logic [NUM_W-1:0] roll_quo;
    logic             yaw_neg;
    logic             roll_neg;
    side_t            side;
  } div_rsp_t;

  // Rotation angle of CORDIC step i, atan(2^-i) in Q28.
  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      0:  a = Z_W'(210828714);
      1:  a = Z_W'(124459457);
      2:  a = Z_W'(65760959);
      3:  a = Z_W'(33381290);
      4:  a = Z_W'(16755422);
      5:  a = Z_W'(8385879);
      6:  a = Z_W'(4193963);
      7:  a = Z_W'(2097109);
      8:  a = Z_W'(1048571);
      9:  a = Z_W'(524287);
      default: a = Z_W'(64'sd1 <<< (28 - i));
    endcase
    return a;
  endfunction

  // Saturate to the signed 32-bit output range.
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] s;
    if (v > 64'sd2147483647) begin
      s = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      s = 32'sh80000000;
    end else begin
      s = OUT_W'(v);
    end
    return s;
  endfunction

endpackage

// File: rtl/btiv_cordic_lane.sv
// One rotation-mode CORDIC lane: angle in, Q15 sine and cosine out.
// Fully pipelined, one iteration per register stage. Depends on btiv_pkg.
module btiv_cordic_lane import btiv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ANG_W-1:0]  angle_i,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(16384);
  localparam logic signed [XY_W-1:0] UNIT_POS   = XY_W'(32768);
  localparam logic signed [XY_W-1:0] UNIT_NEG   = -UNIT_POS;

  logic signed [Z_W-1:0]  z_q   [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] x_q   [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q   [0:CORDIC_STEPS];
  logic                   neg_q [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_in;
  logic signed [XY_W-1:0] x_fin, y_fin, x_rnd, y_rnd;

  // Scale the angle to Q28.
  assign z_in = Z_W'(angle_i) <<< 16;

  // Fold the angle into [-pi/2, pi/2]; the folded result is negated at the end.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      if (z_in > HALF_PI_Q28) begin
        z_q[0]   <= z_in - PI_Q28;
        neg_q[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Q28) begin
        z_q[0]   <= z_in + PI_Q28;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_in;
        neg_q[0] <= 1'b0;
      end
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN = atan_q28(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
      end
    end
  end

  // Undo the fold, round Q30 to Q15 and clamp to the unit range.
  always_comb begin
    x_fin = neg_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    y_fin = neg_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
    x_rnd = (x_fin + ROUND_HALF) >>> 15;
    y_rnd = (y_fin + ROUND_HALF) >>> 15;
    if (x_rnd > UNIT_POS) x_rnd = UNIT_POS;
    if (x_rnd < UNIT_NEG) x_rnd = UNIT_NEG;
    if (y_rnd > UNIT_POS) y_rnd = UNIT_POS;
    if (y_rnd < UNIT_NEG) y_rnd = UNIT_NEG;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= TRIG_W'(x_rnd);
      sin_o <= TRIG_W'(y_rnd);
    end
  end

endmodule

// File: rtl/btiv_merge.sv
// Merge stage: combines the three lanes' sine and cosine with the velocities.
// Builds the rotation matrix, the linear rates, the pitch rate and the divider
// operands over five register stages. Depends on btiv_pkg.
module btiv_merge import btiv_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  trig_t              trig_i,
  input  vel_t               vel_i,
  input  logic [FLOOR_W-1:0] floor_i,
  output div_req_t           req_o
);

  localparam logic signed [P3_W-1:0]  HALF15_P3  = P3_W'(16384);
  localparam logic signed [N1_W-1:0]  HALF15_N1  = N1_W'(16384);
  localparam logic signed [SUM_W-1:0] HALF30_SUM = SUM_W'(64'sd1 <<< 29);

  // Round a Q45 triple product to Q30.
  function automatic logic signed [M_W-1:0] rnd15(input logic signed [P3_W-1:0] v);
    logic signed [P3_W-1:0] t;
    t = (v + HALF15_P3) >>> 15;
    return M_W'(t);
  endfunction

  // Divisor: cos(pitch) clamped to the floor.
  logic [FLOOR_W-1:0] floor_eff;
  logic [DEN_W-1:0]   f8;
  logic [TRIG_W-1:0]  cth_abs;
  logic               clamp;

  always_comb begin
    floor_eff = (floor_i == '0) ? FLOOR_W'(1) : floor_i;
    f8        = {floor_eff, 3'b000};
    cth_abs   = trig_i.cth[TRIG_W-1] ? TRIG_W'(-trig_i.cth) : TRIG_W'(trig_i.cth);
    clamp     = cth_abs < {1'b0, f8};
  end

  // Stage 1: products of two trig values and trig times angular rate.
  logic signed [P2_W-1:0]   cpsi_cth_q, spsi_cphi_q, spsi_sphi_q, spsi_cth_q;
  logic signed [P2_W-1:0]   cpsi_cphi_q, cpsi_sphi_q, cth_sphi_q, cth_cphi_q;
  logic signed [P2_W-1:0]   cpsi_sth_q, sphi_sth_q, sth_spsi_q;
  logic signed [N1_W-1:0]   sq_q, cr_q, cq_q, sr_q;
  logic signed [TRIG_W-1:0] sphi1_q, cphi1_q, spsi1_q, sth1_q;
  vel_t                     vel1_q;
  logic [DEN_W-1:0]         den1_q;
  logic                     dneg1_q, flag1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cpsi_cth_q  <= trig_i.cpsi * trig_i.cth;
      spsi_cphi_q <= trig_i.spsi * trig_i.cphi;
      spsi_sphi_q <= trig_i.spsi * trig_i.sphi;
      spsi_cth_q  <= trig_i.spsi * trig_i.cth;
      cpsi_cphi_q <= trig_i.cpsi * trig_i.cphi;
      cpsi_sphi_q <= trig_i.cpsi * trig_i.sphi;
      cth_sphi_q  <= trig_i.cth * trig_i.sphi;
      cth_cphi_q  <= trig_i.cth * trig_i.cphi;
      cpsi_sth_q  <= trig_i.cpsi * trig_i.sth;
      sphi_sth_q  <= trig_i.sphi * trig_i.sth;
      sth_spsi_q  <= trig_i.sth * trig_i.spsi;
      sq_q        <= trig_i.sphi * vel_i.q;
      cr_q        <= trig_i.cphi * vel_i.r;
      cq_q        <= trig_i.cphi * vel_i.q;
      sr_q        <= trig_i.sphi * vel_i.r;
      sphi1_q     <= trig_i.sphi;
      cphi1_q     <= trig_i.cphi;
      spsi1_q     <= trig_i.spsi;
      sth1_q      <= trig_i.sth;
      vel1_q      <= vel_i;
      den1_q      <= clamp ? f8 : cth_abs[DEN_W-1:0];
      dneg1_q     <= trig_i.cth[TRIG_W-1];
      flag1_q     <= clamp;
    end
  end

  // Stage 2: triple products, the yaw numerator and the pitch rate.
  logic signed [P3_W-1:0]   t1_q, t2_q, t4_q, t5_q;
  logic signed [N1_W-1:0]   n1_q;
  logic signed [OUT_W-1:0]  pitch2_q;
  logic signed [P2_W-1:0]   cpsi_cth2_q, spsi_cphi2_q, spsi_sphi2_q, spsi_cth2_q;
  logic signed [P2_W-1:0]   cpsi_cphi2_q, cpsi_sphi2_q, cth_sphi2_q, cth_cphi2_q;
  logic signed [TRIG_W-1:0] sth2_q;
  vel_t                     vel2_q;
  logic [DEN_W-1:0]         den2_q;
  logic                     dneg2_q, flag2_q;
  logic signed [N1_W-1:0]   pitch_diff, pitch_rnd;

  always_comb begin
    pitch_diff = cq_q - sr_q;
    pitch_rnd  = (pitch_diff + HALF15_N1) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q         <= cpsi_sth_q * sphi1_q;
      t2_q         <= cpsi_cphi_q * sth1_q;
      t4_q         <= sphi_sth_q * spsi1_q;
      t5_q         <= sth_spsi_q * cphi1_q;
      n1_q         <= sq_q + cr_q;
      pitch2_q     <= sat32(64'(pitch_rnd));
      cpsi_cth2_q  <= cpsi_cth_q;
      spsi_cphi2_q <= spsi_cphi_q;
      spsi_sphi2_q <= spsi_sphi_q;
      spsi_cth2_q  <= spsi_cth_q;
      cpsi_cphi2_q <= cpsi_cphi_q;
      cpsi_sphi2_q <= cpsi_sphi_q;
      cth_sphi2_q  <= cth_sphi_q;
      cth_cphi2_q  <= cth_cphi_q;
      sth2_q       <= sth1_q;
      vel2_q       <= vel1_q;
      den2_q       <= den1_q;
      dneg2_q      <= dneg1_q;
      flag2_q      <= flag1_q;
    end
  end

  // Stage 3: matrix entries, sin(pitch) times numerator, yaw divider operand.
  logic signed [M_W-1:0]  m_d [0:8];
  logic signed [M_W-1:0]  m_q [0:8];
  logic signed [SN_W-1:0] sn_q;
  logic [N1_W-1:0]        n1_abs;
  logic [NUM_W-1:0]       yaw_num3_q;
  logic                   yaw_neg3_q;
  logic signed [OUT_W-1:0] pitch3_q;
  vel_t                   vel3_q;
  logic [DEN_W-1:0]       den3_q;
  logic                   dneg3_q, flag3_q;

  always_comb begin
    m_d[0] = M_W'(cpsi_cth2_q);
    m_d[1] = rnd15(t1_q) - M_W'(spsi_cphi2_q);
    m_d[2] = rnd15(t2_q) + M_W'(spsi_sphi2_q);
    m_d[3] = M_W'(spsi_cth2_q);
    m_d[4] = rnd15(t4_q) + M_W'(cpsi_cphi2_q);
    m_d[5] = rnd15(t5_q) - M_W'(cpsi_sphi2_q);
    m_d[6] = -(M_W'(sth2_q) <<< 15);
    m_d[7] = M_W'(cth_sphi2_q);
    m_d[8] = M_W'(cth_cphi2_q);
    n1_abs = n1_q[N1_W-1] ? N1_W'(-n1_q) : N1_W'(n1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        m_q[k] <= m_d[k];
      end
      sn_q       <= sth2_q * n1_q;
      yaw_num3_q <= NUM_W'(n1_abs) + NUM_W'(den2_q >> 1);
      yaw_neg3_q <= n1_q[N1_W-1] ^ dneg2_q;
      pitch3_q   <= pitch2_q;
      vel3_q     <= vel2_q;
      den3_q     <= den2_q;
      dneg3_q    <= dneg2_q;
      flag3_q    <= flag2_q;
    end
  end

  // Stage 4: matrix times linear velocity, roll divider operand.
  logic signed [MV_W-1:0]  mv_q [0:8];
  logic [SN_W-1:0]         sn_abs, roll_sum;
  logic [NUM_W-1:0]        yaw_num4_q, roll_num4_q;
  logic                    yaw_neg4_q, roll_neg4_q, flag4_q;
  logic signed [OUT_W-1:0] pitch4_q;
  logic signed [VEL_W-1:0] p4_q;
  logic [DEN_W-1:0]        den4_q;

  always_comb begin
    sn_abs   = sn_q[SN_W-1] ? SN_W'(-sn_q) : SN_W'(sn_q);
    roll_sum = sn_abs + (SN_W'(den3_q) << 14);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        mv_q[3*k]   <= m_q[3*k]   * vel3_q.u;
        mv_q[3*k+1] <= m_q[3*k+1] * vel3_q.v;
        mv_q[3*k+2] <= m_q[3*k+2] * vel3_q.w;
      end
      roll_num4_q <= NUM_W'(roll_sum >> 15);
      roll_neg4_q <= sn_q[SN_W-1] ^ dneg3_q;
      yaw_num4_q  <= yaw_num3_q;
      yaw_neg4_q  <= yaw_neg3_q;
      pitch4_q    <= pitch3_q;
      p4_q        <= vel3_q.p;
      den4_q      <= den3_q;
      flag4_q     <= flag3_q;
    end
  end

  // Stage 5: sum each row, round by 2^-30 and saturate.
  logic signed [SUM_W-1:0] row_sum [0:2];
  logic signed [SUM_W-1:0] row_rnd [0:2];
  div_req_t                req_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = SUM_W'(mv_q[3*k]) + SUM_W'(mv_q[3*k+1]) + SUM_W'(mv_q[3*k+2]);
      row_rnd[k] = (row_sum[k] + HALF30_SUM) >>> 30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q.side.north      <= sat32(64'(row_rnd[0]));
      req_q.side.east       <= sat32(64'(row_rnd[1]));
      req_q.side.down       <= sat32(64'(row_rnd[2]));
      req_q.side.pitch_rate <= pitch4_q;
      req_q.side.p          <= p4_q;
      req_q.side.flag       <= flag4_q;
      req_q.yaw_num         <= yaw_num4_q;
      req_q.roll_num        <= roll_num4_q;
      req_q.den             <= den4_q;
      req_q.yaw_neg         <= yaw_neg4_q;
      req_q.roll_neg        <= roll_neg4_q;
    end
  end

  assign req_o = req_q;

endmodule

// File: rtl/btiv_div.sv
// Pipelined restoring divider with two lanes (yaw and roll) sharing one divisor.
// One quotient bit per stage; the other results ride alongside. Depends on btiv_pkg.
module btiv_div import btiv_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef struct packed {
    logic [DEN_W-1:0] y_rem;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] y_num;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] y_quo;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] den;
    logic             y_neg;
    logic             r_neg;
    side_t            side;
  } stage_t;

  stage_t st0;
  stage_t st_q [1:NUM_W];

  // Load the numerators into the shift fields with empty remainders.
  always_comb begin
    st0.y_rem = '0;
    st0.r_rem = '0;
    st0.y_num = req_i.yaw_num;
    st0.r_num = req_i.roll_num;
    st0.y_quo = '0;
    st0.r_quo = '0;
    st0.den   = req_i.den;
    st0.y_neg = req_i.yaw_neg;
    st0.r_neg = req_i.roll_neg;
    st0.side  = req_i.side;
  end

  // Each stage brings down one numerator bit and tries one subtraction per lane.
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    stage_t         cur, nxt;
    logic [DEN_W:0] y_try, r_try;

    if (k == 0) begin : g_first
      assign cur = st0;
    end else begin : g_rest
      assign cur = st_q[k];
    end

    always_comb begin
      nxt   = cur;
      y_try = {cur.y_rem, cur.y_num[NUM_W-1]};
      r_try = {cur.r_rem, cur.r_num[NUM_W-1]};
      if (y_try >= {1'b0, cur.den}) begin
        nxt.y_rem = DEN_W'(y_try - {1'b0, cur.den});
        nxt.y_quo = {cur.y_quo[NUM_W-2:0], 1'b1};
      end else begin
        nxt.y_rem = y_try[DEN_W-1:0];
        nxt.y_quo = {cur.y_quo[NUM_W-2:0], 1'b0};
      end
      if (r_try >= {1'b0, cur.den}) begin
        nxt.r_rem = DEN_W'(r_try - {1'b0, cur.den});
        nxt.r_quo = {cur.r_quo[NUM_W-2:0], 1'b1};
      end else begin
        nxt.r_rem = r_try[DEN_W-1:0];
        nxt.r_quo = {cur.r_quo[NUM_W-2:0], 1'b0};
      end
      nxt.y_num = {cur.y_num[NUM_W-2:0], 1'b0};
      nxt.r_num = {cur.r_num[NUM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  assign rsp_o.yaw_quo  = st_q[NUM_W].y_quo;
  assign rsp_o.roll_quo = st_q[NUM_W].r_quo;
  assign rsp_o.yaw_neg  = st_q[NUM_W].y_neg;
  assign rsp_o.roll_neg = st_q[NUM_W].r_neg;
  assign rsp_o.side     = st_q[NUM_W].side;

endmodule

// File: rtl/body_to_inertial_velocity_transform.sv
// Top level of the body-to-inertial velocity transform.
// Instantiates btiv_cordic_lane, btiv_merge and btiv_div; depends on btiv_pkg.
//
//   Port group     Dir  Payload (low bit first)
//   s_axis_*       in   tdata: roll, pitch, yaw angle (15b each), surge, sway,
//                       heave, roll, pitch, yaw velocity (24b each), zero pad
//   m_axis_*       out  tdata: north, east, down, roll, pitch, yaw rate (32b)
//                       tuser: singular flag
//   cfg_*          in   cos pitch floor (13b), written when cfg_we_i is high
//
// One item per clock cycle while the output is not stalled. Each input passes through
// the CORDIC lanes, the merge stage, the bit-per-stage divider and then the output
// register.
// The whole pipeline advances together and holds while a result waits on
// m_axis_tready. Reset clears the valid pipeline and loads the floor with 72.
module body_to_inertial_velocity_transform import btiv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // roll_angle[14:0], pitch_angle[29:15], yaw_angle[44:30], surge_velocity[68:45],
  // sway_velocity[92:69], heave_velocity[116:93], roll_velocity[140:117],
  // pitch_velocity[164:141], yaw_velocity[188:165], zeros[191:189]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // north_rate[31:0], east_rate[63:32], down_rate[95:64], roll_angle_rate[127:96],
  // pitch_angle_rate[159:128], yaw_angle_rate[191:160]
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // singular_flag[0]
  output logic                m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [FLOOR_W-1:0]  cfg_wdata_i
);

  logic                 en;
  logic [TOTAL_LAT-1:0] vld_q;
  logic [FLOOR_W-1:0]   floor_q;
  vel_t                 vel_in;
  vel_t                 vel_q [0:LANE_LAT-1];
  trig_t                trig;
  div_req_t             req;
  div_rsp_t             rsp;

  // The pipeline moves whenever the output register is free or being drained.
  assign en            = !vld_q[TOTAL_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[TOTAL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], s_axis_tvalid};
    end
  end

  // Floor register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  // Velocities wait for the lanes.
  always_comb begin
    vel_in.u = $signed(s_axis_tdata[68:45]);
    vel_in.v = $signed(s_axis_tdata[92:69]);
    vel_in.w = $signed(s_axis_tdata[116:93]);
    vel_in.p = $signed(s_axis_tdata[140:117]);
    vel_in.q = $signed(s_axis_tdata[164:141]);
    vel_in.r = $signed(s_axis_tdata[188:165]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vel_q[0] <= vel_in;
      for (int k = 1; k < LANE_LAT; k++) begin
        vel_q[k] <= vel_q[k-1];
      end
    end
  end

  // One CORDIC lane per Euler angle.
  btiv_cordic_lane u_lane_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ($signed(s_axis_tdata[14:0])),
    .sin_o   (trig.sphi),
    .cos_o   (trig.cphi)
  );

  btiv_cordic_lane u_lane_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ($signed(s_axis_tdata[29:15])),
    .sin_o   (trig.sth),
    .cos_o   (trig.cth)
  );

  btiv_cordic_lane u_lane_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i ($signed(s_axis_tdata[44:30])),
    .sin_o   (trig.spsi),
    .cos_o   (trig.cpsi)
  );

  btiv_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .trig_i  (trig),
    .vel_i   (vel_q[LANE_LAT-1]),
    .floor_i (floor_q),
    .req_o   (req)
  );

  btiv_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Apply signs, add the roll rate and saturate into the output register.
  logic signed [NUM_W:0]   yaw_mag, roll_mag, yaw_s, roll_s;
  logic signed [NUM_W+1:0] roll_sum;
  logic [M_DATA_W-1:0]     tdata_q;
  logic                    tuser_q;

  always_comb begin
    yaw_mag  = $signed({1'b0, rsp.yaw_quo});
    roll_mag = $signed({1'b0, rsp.roll_quo});
    yaw_s    = rsp.yaw_neg ? -yaw_mag : yaw_mag;
    roll_s   = rsp.roll_neg ? -roll_mag : roll_mag;
    roll_sum = (NUM_W+2)'(rsp.side.p) + (NUM_W+2)'(roll_s);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {sat32(64'(yaw_s)), rsp.side.pitch_rate, sat32(64'(roll_sum)),
                  rsp.side.down, rsp.side.east, rsp.side.north};
      tuser_q <= rsp.side.flag;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

endmodule

// File: rtl/btiv_checker.sv
// Port-level checker for the body-to-inertial velocity transform, with its bind.
// Sees only the top-level ports; depends on btiv_pkg.
module btiv_checker import btiv_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // A result that was not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // Input is taken exactly when the output side can move.
  a_ready_link: assert property (@(posedge clk_i)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // No result is shown during reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // The output stage does not fill out of nothing: no result is shown in the
  // first cycle after reset, whatever the input does.
  a_first_empty: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  logic unused_in;
  assign unused_in = s_axis_tvalid;

endmodule

bind body_to_inertial_velocity_transform btiv_checker u_btiv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
